// ----- rtl/core/sgc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgc_pkg
// Shared widths, command codes and status codes of the graph colouring unit.
// ----------------------------------------------------------------------------
package sgc_pkg;

  // default graph size
  localparam int NODES_DEF = 64;

  // fixed field widths
  localparam int CMD_W = 2;
  localparam int IDX_W = 6;
  localparam int COL_W = 7;
  localparam int ST_W  = 2;
  localparam int CFG_W = 7;

  // reset value of the node count register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COLOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_REJ   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

// ----- rtl/core/speculative_graph_coloring_unit.sv -----
// ----------------------------------------------------------------------------
// speculative_graph_coloring_unit
// Graph store with greedy colouring in node order, adjacency and colours
// held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command per transfer: add an
//   edge, colour the graph, or clear it. Output channel (out_valid/out_ready)
//   gives one result per add or clear, and one result per node in use after
//   a colour command, the final one marked by out_last.
//   cfg_wr_en/cfg_wr_data set the node count; write it only while idle.
// Sequencing:
//   clear: answered at once; add edge: row a read, checked, then rows a and
//   b written, no writes for a duplicate, answered at once for a self loop
//   or an endpoint out of range; command 3 is dropped with no result.
//   colour: per node i, its row is read, then the colour of each lower node
//   is read from the colour memory, one per cycle, and kept if it is a
//   neighbour, plus a one-bit-a-cycle search for the lowest free colour;
//   results then follow in node order, each held until the output is free.
//   One command is worked on at a time; a new one is taken once the last
//   result sits in the output register and any adjacency write is done.
// Reset: synchronous, active low; graph empties at once (per-row valid
//   bits), node count returns to 64, no clearing pass.
// Stall: a held output register stops the sequencer until it is taken.
// ----------------------------------------------------------------------------
module speculative_graph_coloring_unit
  import sgc_pkg::*;
#(
  parameter int NODES = NODES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  logic [IDX_W-1:0] in_node_a,
  input  logic [IDX_W-1:0] in_node_b,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ST_W-1:0]  out_status,
  output logic [IDX_W-1:0] out_node_index,
  output logic [COL_W-1:0] out_node_color,
  output logic             out_last,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int UW = 2 ** CW;

  typedef enum logic [3:0] {
    S_IDLE, S_RESP, A_RDA, A_RDB, A_CHK, A_WRB,
    C_ROW, C_ROWD, C_SCAN, C_FREE, E_RD, E_DAT
  } state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  cfg_r;
  logic [CW-1:0]     n_cnt;
  logic [CW-1:0]     i_r, j_r, c_r;
  logic [UW-1:0]     used_r;
  logic              pend_r;
  logic [NODES-1:0]  row_r;
  logic [IW-1:0]     a_r, b_r;
  logic [ST_W-1:0]   st_r;
  logic              out_free;
  logic              out_load;
  logic              in_fire;

  // output register
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [COL_W-1:0]  out_color_r;
  logic              out_last_r;

  // adjacency memory with per-row valid bits
  logic [NODES-1:0]  adj_mem [NODES];
  logic [NODES-1:0]  row_valid_r;
  logic [IW-1:0]     adj_raddr;
  logic [NODES-1:0]  adj_rdata_r;
  logic              adj_rvalid_r;
  logic [NODES-1:0]  adj_row;
  logic              adj_we;
  logic [IW-1:0]     adj_waddr;
  logic [NODES-1:0]  adj_wdata;

  // colour memory, written before read within a colour pass
  logic [CW-1:0]     col_mem [NODES];
  logic [IW-1:0]     col_raddr;
  logic [CW-1:0]     col_rdata_r;
  logic              col_we;

  // node count, saturated to 1..NODES
  always_comb begin
    if (cfg_r == '0) begin
      n_cnt = CW'(1);
    end else if (cfg_r > CFG_W'(NODES)) begin
      n_cnt = CW'(NODES);
    end else begin
      n_cnt = cfg_r[CW-1:0];
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign adj_row  = adj_rvalid_r ? adj_rdata_r : '0;

  // a result enters the output register this cycle
  assign out_load = out_free &&
                    (state_r == S_RESP || state_r == A_CHK || state_r == E_DAT);

  // memory port control
  always_comb begin
    adj_raddr = b_r;
    adj_we    = 1'b0;
    adj_waddr = a_r;
    adj_wdata = row_r | (NODES'(1) << b_r);
    col_raddr = i_r[IW-1:0];
    col_we    = 1'b0;
    case (state_r)
      A_RDA:  adj_raddr = a_r;
      A_CHK:  adj_we    = out_free && !row_r[b_r];
      A_WRB: begin
        adj_we    = 1'b1;
        adj_waddr = b_r;
        adj_wdata = adj_row | (NODES'(1) << a_r);
      end
      C_ROW:  adj_raddr = i_r[IW-1:0];
      C_SCAN: col_raddr = j_r[IW-1:0];
      C_FREE: col_we    = !used_r[c_r];
      default: ;
    endcase
  end

  // adjacency memory
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  // row valid bits: cleared by reset and by the clear command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r  <= '0;
      adj_rvalid_r <= 1'b0;
    end else begin
      adj_rvalid_r <= row_valid_r[adj_raddr];
      if (in_fire && in_command == CMD_CLEAR) begin
        row_valid_r <= '0;
      end else if (adj_we) begin
        row_valid_r[adj_waddr] <= 1'b1;
      end
    end
  end

  // colour memory
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[i_r[IW-1:0]] <= c_r;
    end
    col_rdata_r <= col_mem[col_raddr];
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            a_r <= in_node_a[IW-1:0];
            b_r <= in_node_b[IW-1:0];
            i_r <= '0;
            case (in_command)
              CMD_ADD: begin
                if (CFG_W'(in_node_a) >= CFG_W'(n_cnt) ||
                    CFG_W'(in_node_b) >= CFG_W'(n_cnt)) begin
                  st_r    <= ST_RANGE;
                  state_r <= S_RESP;
                end else if (in_node_a == in_node_b) begin
                  st_r    <= ST_REJ;
                  state_r <= S_RESP;
                end else begin
                  state_r <= A_RDA;
                end
              end
              CMD_COLOR: state_r <= C_ROW;
              CMD_CLEAR: begin
                st_r    <= ST_OK;
                state_r <= S_RESP;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_status_r <= st_r;
            out_index_r  <= '0;
            out_color_r  <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        A_RDA: state_r <= A_RDB;
        A_RDB: begin
          row_r   <= adj_row;
          state_r <= A_CHK;
        end
        A_CHK: begin
          if (out_free) begin
            out_index_r  <= '0;
            out_color_r  <= '0;
            out_last_r   <= 1'b1;
            if (row_r[b_r]) begin
              out_status_r <= ST_REJ;
              state_r      <= S_IDLE;
            end else begin
              out_status_r <= ST_OK;
              state_r      <= A_WRB;
            end
          end
        end
        A_WRB: state_r <= S_IDLE;
        // one node: fetch its row, gather lower neighbours' colours
        C_ROW: state_r <= C_ROWD;
        C_ROWD: begin
          row_r   <= adj_row;
          j_r     <= '0;
          pend_r  <= 1'b0;
          used_r  <= '0;
          state_r <= C_SCAN;
        end
        C_SCAN: begin
          if (pend_r) begin
            used_r[col_rdata_r] <= 1'b1;
          end
          if (j_r == i_r) begin
            pend_r  <= 1'b0;
            c_r     <= CW'(1);
            state_r <= C_FREE;
          end else begin
            pend_r <= row_r[j_r[IW-1:0]];
            j_r    <= j_r + CW'(1);
          end
        end
        // lowest free colour, one candidate a cycle
        C_FREE: begin
          if (used_r[c_r]) begin
            c_r <= c_r + CW'(1);
          end else if (i_r + CW'(1) == n_cnt) begin
            i_r     <= '0;
            state_r <= E_RD;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= C_ROW;
          end
        end
        // report colours in node order
        E_RD: state_r <= E_DAT;
        E_DAT: begin
          if (out_free) begin
            out_status_r <= ST_OK;
            out_index_r  <= IDX_W'(i_r[IW-1:0]);
            out_color_r  <= COL_W'(col_rdata_r);
            out_last_r   <= (i_r + CW'(1) == n_cnt);
            i_r          <= i_r + CW'(1);
            state_r      <= (i_r + CW'(1) == n_cnt) ? S_IDLE : E_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_index_r;
  assign out_node_color = out_color_r;
  assign out_last       = out_last_r;

  // a chosen colour is never 0 and never beyond the node's own index plus one
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_we |-> (c_r != '0) && (c_r <= i_r + CW'(1)))
    else $error("colour out of range");

  // rows are only written for nodes in use
  a_adj_wr: assert property (@(posedge clk) disable iff (!rst_n)
    adj_we |-> CFG_W'(adj_waddr) < CFG_W'(n_cnt))
    else $error("adjacency write outside node range");

  // the neighbour scan never passes the node being coloured
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_SCAN |-> j_r <= i_r)
    else $error("neighbour scan overran");

  // a colour result names a node in use
  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == E_DAT |-> i_r < n_cnt)
    else $error("report index beyond node count");

endmodule
